// File: src/sppr_pkg.sv
// Shared types and constants of the setpoint profile pressure regulator.
`timescale 1ns / 1ps

package sppr_pkg;

   // field widths
   localparam int SP_W        = 17;
   localparam int ERR_W       = 18;
   localparam int FREQ_W      = 16;
   localparam int GAIN_W      = 16;
   localparam int CGAIN_W     = 10;
   localparam int BAND_W      = 10;
   localparam int TIME_W      = 32;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   // setpoint cap, coarse path offset and frequency saturation value
   localparam logic [SP_W-1:0]   SETPOINT_CAP  = 17'd100000;
   localparam logic [FREQ_W-1:0] COARSE_OFFSET = 16'd12;
   localparam logic [FREQ_W-1:0] FREQ_SAT      = 16'hFFFF;

   // x / 1000 == ((x >> 3) * RECIP) >> 37, exact for x below 2^33
   localparam int PROD_W      = SP_W + GAIN_W;
   localparam int DIV_PRESHIFT = 3;
   localparam int RECIP_W     = 31;
   localparam int RECIP_SHIFT = 37;
   localparam int RP_W        = PROD_W - DIV_PRESHIFT + RECIP_W;
   localparam int QUOT_W      = RP_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP = 31'd1099511628;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_HOLD    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COARSE_THR  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COARSE_GAIN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINE_GAIN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREQ_MAX    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREQ_MIN    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_BAND   = 3'd7;

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_SAMPLE  = 2'd1,
      ACT_LOAD    = 2'd2,
      ACT_COMMAND = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CMD_PAUSE    = 3'd0,
      CMD_CONTINUE = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_START    = 3'd3,
      CMD_HOME     = 3'd4,
      CMD_SETUP    = 3'd5
   } command_type;

   typedef enum logic [2:0] {
      ST_PAUSED  = 3'd0,
      ST_RUNNING = 3'd1,
      ST_STOPPED = 3'd2,
      ST_SETUP   = 3'd3,
      ST_HOME    = 3'd4
   } status_type;

   // what the held frequency does when the transaction retires
   typedef enum logic [1:0] {
      FOP_KEEP = 2'd0,
      FOP_SET  = 2'd1,
      FOP_ZERO = 2'd2
   } freq_op_type;

   typedef struct packed {
      freq_op_type              op;
      logic                     direction;
      status_type               status;
      logic [SP_W-1:0]          setpoint;
      logic signed [ERR_W-1:0]  error;
   } rsp_meta_type;

   typedef struct packed {
      logic [SP_W-1:0]    threshold;
      logic [CGAIN_W-1:0] coarse_gain;
      logic [GAIN_W-1:0]  fine_gain;
      logic [FREQ_W-1:0]  freq_max;
      logic [FREQ_W-1:0]  freq_min;
      logic [BAND_W-1:0]  stop_band;
   } freq_cfg_type;

endpackage

// File: src/sppr_freq_pipe.sv
// Pulse frequency pipeline, held frequency and response register.
`timescale 1ns / 1ps

module sppr_freq_pipe
   import sppr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  freq_cfg_type           cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rsp_meta_type           in_meta,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] pulse_freq_hz, [16] direction, [19:17] run_status,
   // [36:20] active_setpoint_mbar, [54:37] error_mbar, [55] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

   rsp_meta_type s1_meta_ff, s2_meta_ff, s3_meta_ff, s4_meta_ff;

   logic [SP_W-1:0]   s2_abs_ff;
   logic [GAIN_W-1:0] s2_gain_ff;
   logic              s2_coarse_ff, s2_stop_ff;
   logic [PROD_W-1:0] s3_prod_ff;
   logic              s3_coarse_ff, s3_stop_ff;
   logic [QUOT_W-1:0] s4_quot_ff;
   logic              s4_coarse_ff, s4_stop_ff;

   logic [FREQ_W-1:0]      held_freq_ff, held_freq_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [SP_W-1:0]    s2_abs_in;
   logic [GAIN_W-1:0]  s2_gain_in;
   logic               s2_coarse_in, s2_stop_in;
   logic [ERR_W-1:0]   neg_err;
   logic [RP_W-1:0]    recip_prod;
   logic [QUOT_W:0]    coarse_sum;
   logic [FREQ_W-1:0]  coarse_freq, fine_freq, rate_freq;

   // bubble-collapsing handshake
   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_ready  = s1_ready;

   // stage 1 -> 2: magnitude, path select, stop band check, gain select
   always_comb begin
      neg_err   = ERR_W'(-s1_meta_ff.error);
      s2_abs_in = s1_meta_ff.error[ERR_W-1] ? neg_err[SP_W-1:0]
                                            : s1_meta_ff.error[SP_W-1:0];
      s2_coarse_in = s2_abs_in > cfg.threshold;
      s2_stop_in   = s2_abs_in <= SP_W'(cfg.stop_band);
      s2_gain_in   = s2_coarse_in ? GAIN_W'(cfg.coarse_gain) : cfg.fine_gain;
   end

   // stage 3 -> 4: divide by 1000 through the reciprocal
   assign recip_prod = RP_W'(s3_prod_ff[PROD_W-1:DIV_PRESHIFT]) * RP_W'(RECIP);

   // stage 4: clamps and saturation
   always_comb begin
      coarse_sum  = (QUOT_W+1)'(s4_quot_ff) + (QUOT_W+1)'(COARSE_OFFSET);
      coarse_freq = (|coarse_sum[QUOT_W:FREQ_W]) ? FREQ_SAT : coarse_sum[FREQ_W-1:0];
      fine_freq   = (s4_quot_ff > QUOT_W'(cfg.freq_max)) ? cfg.freq_max
                                                          : s4_quot_ff[FREQ_W-1:0];
      if (fine_freq < cfg.freq_min) begin
         fine_freq = cfg.freq_min;
      end
      if (s4_stop_ff) begin
         fine_freq = '0;
      end
      rate_freq = s4_coarse_ff ? coarse_freq : fine_freq;
   end

   always_comb begin
      case (s4_meta_ff.op)
         FOP_SET:  held_freq_in = rate_freq;
         FOP_ZERO: held_freq_in = '0;
         default:  held_freq_in = held_freq_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_freq_ff <= '0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s4_valid_ff;
         end
         if (out_ready && s4_valid_ff) begin
            held_freq_ff <= held_freq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_meta_ff <= in_meta;
      end
      if (s2_ready) begin
         s2_meta_ff   <= s1_meta_ff;
         s2_abs_ff    <= s2_abs_in;
         s2_gain_ff   <= s2_gain_in;
         s2_coarse_ff <= s2_coarse_in;
         s2_stop_ff   <= s2_stop_in;
      end
      if (s3_ready) begin
         s3_meta_ff   <= s2_meta_ff;
         s3_prod_ff   <= PROD_W'(s2_abs_ff) * PROD_W'(s2_gain_ff);
         s3_coarse_ff <= s2_coarse_ff;
         s3_stop_ff   <= s2_stop_ff;
      end
      if (s4_ready) begin
         s4_meta_ff   <= s3_meta_ff;
         s4_quot_ff   <= recip_prod[RP_W-1:RECIP_SHIFT];
         s4_coarse_ff <= s3_coarse_ff;
         s4_stop_ff   <= s3_stop_ff;
      end
      if (out_ready) begin
         rsp_data_ff <= {1'b0, s4_meta_ff.error, s4_meta_ff.setpoint,
                         s4_meta_ff.status, s4_meta_ff.direction, held_freq_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/setpoint_profile_pressure_regulator.sv
// Top level of the setpoint profile pressure regulator.
`timescale 1ns / 1ps

// Takes one transaction per clock (tick, sample, list load or command) while
// req_tready is high and returns one response per transaction, in order. The
// control state is updated in the cycle of acceptance; the setpoint list sits
// in a synchronous memory with one read and one write port that is read ahead
// at the next list index every cycle, with a bypass when a load writes that
// same entry, so a tick that takes a new setpoint needs no stall. The pulse
// frequency then passes a four-stage pipeline (magnitude and path select, gain
// multiply, divide by 1000 as a reciprocal multiply, clamps) and a response
// register, which together keep up with one transaction per cycle while
// rsp_tready is high. Up to five transactions are buffered while rsp_tready
// is low. The list memory is not cleared after reset; entries beyond the
// loaded count are never taken as a setpoint.

module setpoint_profile_pressure_regulator
   import sppr_pkg::*;
#(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [16:0] pressure_mbar, [33:17] setpoint_mbar, [34] first_entry,
   // [37:35] command_code, [39:38] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] pulse_freq_hz, [16] direction, [19:17] run_status,
   // [36:20] active_setpoint_mbar, [54:37] error_mbar, [55] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // configuration
   logic [15:0]        step_period_ff, end_hold_ff;
   freq_cfg_type       freq_cfg_ff;

   // control state
   status_type              status_ff, status_in;
   logic [TIME_W-1:0]       step_el_ff, step_el_in;
   logic [TIME_W-1:0]       take_el_ff, take_el_in;
   logic [CW-1:0]           entry_count_ff, entry_count_in;
   logic [CW-1:0]           next_index_ff, next_index_in;
   logic [SP_W-1:0]         setpoint_ff, setpoint_in;
   logic                    direction_ff, direction_in;
   logic signed [ERR_W-1:0] error_ff, error_in;

   // list memory
   logic [SP_W-1:0] profile_mem [TABLE_DEPTH];
   logic [SP_W-1:0] mem_q_ff, byp_data_ff, rd_val;
   logic            byp_hit_ff;
   logic            mem_wen;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [CW-1:0]   load_base;

   // transaction decode
   logic              accept;
   action_type        action;
   command_type       command;
   logic [SP_W-1:0]   pressure, load_value;
   logic              first_entry;
   logic              step_due, hold_done;
   logic signed [ERR_W-1:0] sample_err;
   rsp_meta_type      meta;
   logic              pipe_ready;

   assign action      = action_type'(req_tuser);
   assign pressure    = req_tdata[16:0];
   assign load_value  = req_tdata[33:17];
   assign first_entry = req_tdata[34];
   assign command     = command_type'(req_tdata[37:35]);
   assign accept      = req_tvalid && pipe_ready;
   assign req_tready  = pipe_ready;

   assign rd_val = byp_hit_ff ? byp_data_ff : mem_q_ff;

   // elapsed counters stand for clock minus start/take stamps; the model's
   // (elapsed + 1) > limit turns into elapsed >= limit without the wrap
   assign step_due  = (step_el_ff >= TIME_W'(step_period_ff)) && !(&step_el_ff);
   assign hold_done = (take_el_ff >= TIME_W'(end_hold_ff)) && !(&take_el_ff);

   assign sample_err = ERR_W'($signed({1'b0, setpoint_ff})) -
                       ERR_W'($signed({1'b0, pressure}));

   assign load_base = first_entry ? '0 : entry_count_ff;
   assign wr_addr   = load_base[AW-1:0];
   assign rd_addr   = next_index_in[AW-1:0];

   always_comb begin
      status_in      = status_ff;
      step_el_in     = step_el_ff;
      take_el_in     = take_el_ff;
      entry_count_in = entry_count_ff;
      next_index_in  = next_index_ff;
      setpoint_in    = setpoint_ff;
      direction_in   = direction_ff;
      error_in       = error_ff;
      mem_wen        = 1'b0;
      if (accept) begin
         case (action)
            ACT_TICK: begin
               step_el_in = step_el_ff + 1'b1;
               take_el_in = take_el_ff + 1'b1;
               if (status_ff == ST_RUNNING && step_due) begin
                  step_el_in = '0;
                  if (next_index_ff < entry_count_ff) begin
                     setpoint_in   = (rd_val > SETPOINT_CAP) ? SETPOINT_CAP : rd_val;
                     next_index_in = CW'(next_index_ff + 1'b1);
                     take_el_in    = '0;
                  end else if (hold_done) begin
                     status_in = ST_PAUSED;
                  end
               end
            end
            ACT_SAMPLE: begin
               error_in     = sample_err;
               direction_in = !(!sample_err[ERR_W-1] && (|sample_err));
            end
            ACT_LOAD: begin
               if (first_entry) begin
                  entry_count_in = '0;
                  next_index_in  = '0;
               end
               if (load_base < CW'(TABLE_DEPTH)) begin
                  mem_wen        = 1'b1;
                  entry_count_in = CW'(load_base + 1'b1);
               end
            end
            ACT_COMMAND: begin
               case (command)
                  CMD_PAUSE:    status_in = ST_PAUSED;
                  CMD_CONTINUE: status_in = ST_RUNNING;
                  CMD_STOP:     status_in = ST_STOPPED;
                  CMD_START: begin
                     status_in     = ST_RUNNING;
                     step_el_in    = '0;
                     take_el_in    = '0;
                     next_index_in = '0;
                  end
                  CMD_HOME:     status_in = ST_HOME;
                  CMD_SETUP:    status_in = ST_SETUP;
                  default:      ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // response fields as they stand after this transaction
   always_comb begin
      meta.direction = direction_in;
      meta.status    = status_in;
      meta.setpoint  = setpoint_in;
      meta.error     = error_in;
      if (status_in == ST_PAUSED) begin
         meta.op = FOP_ZERO;
      end else if (action == ACT_SAMPLE && status_ff == ST_RUNNING) begin
         meta.op = FOP_SET;
      end else begin
         meta.op = FOP_KEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff      <= ST_PAUSED;
         step_el_ff     <= '0;
         take_el_ff     <= '0;
         entry_count_ff <= '0;
         next_index_ff  <= '0;
         setpoint_ff    <= '0;
         direction_ff   <= 1'b0;
         error_ff       <= '0;
         byp_hit_ff     <= 1'b0;
      end else begin
         status_ff      <= status_in;
         step_el_ff     <= step_el_in;
         take_el_ff     <= take_el_in;
         entry_count_ff <= entry_count_in;
         next_index_ff  <= next_index_in;
         setpoint_ff    <= setpoint_in;
         direction_ff   <= direction_in;
         error_ff       <= error_in;
         byp_hit_ff     <= mem_wen && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wen) begin
         profile_mem[wr_addr] <= load_value;
      end
      mem_q_ff    <= profile_mem[rd_addr];
      byp_data_ff <= load_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff          <= 16'd1000;
         end_hold_ff             <= 16'd5000;
         freq_cfg_ff.threshold   <= 17'd2000;
         freq_cfg_ff.coarse_gain <= 10'd200;
         freq_cfg_ff.fine_gain   <= 16'd1000;
         freq_cfg_ff.freq_max    <= 16'd2400;
         freq_cfg_ff.freq_min    <= 16'd6;
         freq_cfg_ff.stop_band   <= 10'd10;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_STEP_PERIOD: step_period_ff          <= csr_wdata[15:0];
            CSR_END_HOLD:    end_hold_ff             <= csr_wdata[15:0];
            CSR_COARSE_THR:  freq_cfg_ff.threshold   <= csr_wdata;
            CSR_COARSE_GAIN: freq_cfg_ff.coarse_gain <= csr_wdata[CGAIN_W-1:0];
            CSR_FINE_GAIN:   freq_cfg_ff.fine_gain   <= csr_wdata[GAIN_W-1:0];
            CSR_FREQ_MAX:    freq_cfg_ff.freq_max    <= csr_wdata[FREQ_W-1:0];
            CSR_FREQ_MIN:    freq_cfg_ff.freq_min    <= csr_wdata[FREQ_W-1:0];
            CSR_STOP_BAND:   freq_cfg_ff.stop_band   <= csr_wdata[BAND_W-1:0];
            default:         ;
         endcase
      end
   end

   sppr_freq_pipe u_freq_pipe (
      .clock      (clock),
      .reset      (reset),
      .cfg        (freq_cfg_ff),
      .in_valid   (accept),
      .in_ready   (pipe_ready),
      .in_meta    (meta),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/regulator_checker.sv
// Checker for the setpoint profile pressure regulator: tracks state, predicts and compares.
`timescale 1ns / 1ps

module regulator_checker
   import sppr_pkg::*;
#(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam int unsigned MBAR_PER_BAR = 1000;

   // same layout as rsp_tdata[54:0], highest field first
   typedef struct packed {
      logic [ERR_W-1:0]  error;
      logic [SP_W-1:0]   setpoint;
      logic [2:0]        status;
      logic              direction;
      logic [FREQ_W-1:0] pulse_freq;
   } regulator_view_type;

   regulator_view_type expected_outputs[$];

   int unsigned reg_step_period, reg_end_hold, reg_coarse_thr, reg_coarse_gain;
   int unsigned reg_fine_gain, reg_freq_max, reg_freq_min, reg_stop_band;

   int unsigned       ms_clock, step_start, last_take;
   int unsigned       list_count, list_next;
   status_type        run_state;
   logic [SP_W-1:0]   profile_mem [TABLE_DEPTH];
   logic [SP_W-1:0]   cur_setpoint;
   logic [FREQ_W-1:0] held_freq;
   logic              held_dir;
   int                last_err;

   function automatic logic [FREQ_W-1:0] pulse_rate(int unsigned mag);
      longint unsigned f;
      f = mag;
      if (mag > reg_coarse_thr) begin
         f = f * reg_coarse_gain / MBAR_PER_BAR + COARSE_OFFSET;
      end else begin
         f = f * reg_fine_gain / MBAR_PER_BAR;
         if (f > reg_freq_max) f = reg_freq_max;
         if (f < reg_freq_min) f = reg_freq_min;
         if (mag <= reg_stop_band) f = 0;
      end
      return (f > FREQ_SAT) ? FREQ_SAT : f[FREQ_W-1:0];
   endfunction

   task automatic reset_state();
      reg_step_period = 1000;
      reg_end_hold    = 5000;
      reg_coarse_thr  = 2000;
      reg_coarse_gain = 200;
      reg_fine_gain   = 1000;
      reg_freq_max    = 2400;
      reg_freq_min    = 6;
      reg_stop_band   = 10;
      ms_clock     = 0;
      step_start   = 0;
      last_take    = 0;
      run_state    = ST_PAUSED;
      list_count   = 0;
      list_next    = 0;
      cur_setpoint = '0;
      held_freq    = '0;
      held_dir     = 1'b0;
      last_err     = 0;
      expected_outputs.delete();
   endtask

   task automatic regulate_step(logic [1:0] act, logic [REQ_TDATA_W-1:0] data);
      logic [SP_W-1:0] pressure, sp, v;
      logic            first_flag;
      logic [2:0]      code;
      int unsigned     mag;
      regulator_view_type want;
      pressure   = data[16:0];
      sp         = data[33:17];
      first_flag = data[34];
      code       = data[37:35];
      case (act)
         ACT_TICK: begin
            ms_clock++;
            // elapsed times wrap modulo 2^32 by unsigned subtraction
            if (run_state == ST_RUNNING && ms_clock - step_start > reg_step_period) begin
               step_start = ms_clock;
               if (list_next < list_count && list_next < TABLE_DEPTH) begin
                  v = profile_mem[list_next];
                  cur_setpoint = (v > SETPOINT_CAP) ? SETPOINT_CAP : v;
                  list_next++;
                  last_take = ms_clock;
               end else if (ms_clock - last_take > reg_end_hold) begin
                  run_state = ST_PAUSED;
               end
            end
         end
         ACT_SAMPLE: begin
            last_err = int'(cur_setpoint) - int'(pressure);
            mag = (last_err < 0) ? -last_err : last_err;
            held_dir = (last_err > 0) ? 1'b0 : 1'b1;
            if (run_state == ST_RUNNING) held_freq = pulse_rate(mag);
            else if (run_state == ST_PAUSED) held_freq = '0;
         end
         ACT_LOAD: begin
            if (first_flag) begin
               list_count = 0;
               list_next  = 0;
            end
            if (list_count < TABLE_DEPTH) begin
               profile_mem[list_count] = sp;
               list_count++;
            end
         end
         default: begin
            case (code)
               CMD_PAUSE:    run_state = ST_PAUSED;
               CMD_CONTINUE: run_state = ST_RUNNING;
               CMD_STOP:     run_state = ST_STOPPED;
               CMD_START: begin
                  run_state  = ST_RUNNING;
                  step_start = ms_clock;
                  last_take  = ms_clock;
                  list_next  = 0;
               end
               CMD_HOME:     run_state = ST_HOME;
               CMD_SETUP:    run_state = ST_SETUP;
               default: ;
            endcase
         end
      endcase
      if (run_state == ST_PAUSED) held_freq = '0;
      want.error      = last_err[ERR_W-1:0];
      want.setpoint   = cur_setpoint;
      want.status     = run_state;
      want.direction  = held_dir;
      want.pulse_freq = held_freq;
      expected_outputs.push_back(want);
   endtask

   task automatic check_field(string field, logic signed [31:0] want_v,
                              logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      regulator_view_type got, want;
      if (reset) begin
         reset_state();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_STEP_PERIOD: reg_step_period = csr_wdata[15:0];
               CSR_END_HOLD:    reg_end_hold    = csr_wdata[15:0];
               CSR_COARSE_THR:  reg_coarse_thr  = csr_wdata[16:0];
               CSR_COARSE_GAIN: reg_coarse_gain = csr_wdata[9:0];
               CSR_FINE_GAIN:   reg_fine_gain   = csr_wdata[15:0];
               CSR_FREQ_MAX:    reg_freq_max    = csr_wdata[15:0];
               CSR_FREQ_MIN:    reg_freq_min    = csr_wdata[15:0];
               CSR_STOP_BAND:   reg_stop_band   = csr_wdata[9:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(regulator_view_type)-1:0];
            if (expected_outputs.size() == 0) begin
               $error("response transaction with nothing outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_outputs.pop_front();
               check_field("pulse_freq_hz", want.pulse_freq, got.pulse_freq);
               check_field("direction", want.direction, got.direction);
               check_field("run_status", want.status, got.status);
               check_field("active_setpoint_mbar", want.setpoint, got.setpoint);
               check_field("error_mbar", $signed(want.error), $signed(got.error));
            end
         end
         if (req_tvalid && req_tready) regulate_step(req_tuser, req_tdata);
      end
      pending <= expected_outputs.size();
   end

endmodule

// File: tb/testbench.sv
// Top of the regulator testbench: clock, reset, stimulus, config phases and verdict.
`timescale 1ns / 1ps

module testbench;
   import sppr_pkg::*;

   localparam int TABLE_DEPTH  = 256;
   localparam int SP_MAX       = 131071;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 170;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int   fail_count;
   int   pending;
   int   items_sent = 0;
   int   cycle_count = 0;
   logic idle_on = 1'b1;
   logic hold_requested = 1'b0;

   setpoint_profile_pressure_regulator #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   regulator_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         if (hold_requested) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_requested = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   task automatic send_item(action_type act, logic [SP_W-1:0] pres, logic [SP_W-1:0] sp,
                            logic first_flag, logic [2:0] code);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {2'b00, code, first_flag, sp, pres};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic csr_put(logic [CSR_INDEX_W-1:0] idx, int unsigned val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   task automatic configure(int unsigned step, int unsigned hold, int unsigned thr,
                            int unsigned cgain, int unsigned fgain, int unsigned fmax,
                            int unsigned fmin, int unsigned band);
      csr_put(CSR_STEP_PERIOD, step);
      csr_put(CSR_END_HOLD, hold);
      csr_put(CSR_COARSE_THR, thr);
      csr_put(CSR_COARSE_GAIN, cgain);
      csr_put(CSR_FINE_GAIN, fgain);
      csr_put(CSR_FREQ_MAX, fmax);
      csr_put(CSR_FREQ_MIN, fmin);
      csr_put(CSR_STOP_BAND, band);
      csr_wen <= 1'b0;
   endtask

   // every transaction returns a response, so an empty queue means idle
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [SP_W-1:0] loaded [8];
      logic [SP_W-1:0] base;
      int              n_loaded, stop_at, pick, delta, pres_i, roll;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: short step period so the list moves within a few ticks
      configure(1, 3, 2000, 200, 1000, 2400, 6, 10);
      send_item(ACT_SAMPLE, '0, '0, 1'b0, '0);
      send_item(ACT_SAMPLE, SP_W'(SP_MAX), '0, 1'b0, '0);
      send_item(ACT_COMMAND, '0, '0, 1'b0, CMD_START);    // empty list
      repeat (4) send_item(ACT_TICK, '0, '0, 1'b0, '0);   // end hold runs out
      send_item(ACT_LOAD, '0, SP_W'(SP_MAX), 1'b1, '0);    // above the cap
      send_item(ACT_LOAD, SP_W'(SP_MAX), 17'd1500, 1'b0, 3'b111);
      send_item(ACT_COMMAND, '0, '0, 1'b0, CMD_START);
      repeat (2) send_item(ACT_TICK, '0, '0, 1'b0, '0);
      send_item(ACT_SAMPLE, 17'd100000, '0, 1'b0, '0);     // zero error
      send_item(ACT_SAMPLE, 17'd99995, '0, 1'b0, '0);      // inside stop band
      send_item(ACT_SAMPLE, '0, '0, 1'b0, '0);             // coarse
      send_item(ACT_SAMPLE, SP_W'(SP_MAX), '0, 1'b0, '0);  // negative error
      send_item(ACT_COMMAND, '0, '0, 1'b0, CMD_STOP);
      send_item(ACT_SAMPLE, 17'd99000, '0, 1'b0, '0);      // held while stopped
      send_item(ACT_COMMAND, '0, '0, 1'b0, CMD_SETUP);
      send_item(ACT_COMMAND, '0, '0, 1'b0, CMD_HOME);
      send_item(ACT_COMMAND, '0, '0, 1'b0, CMD_SPARE_LO);
      send_item(ACT_COMMAND, '0, '0, 1'b0, CMD_SPARE_HI);
      send_item(ACT_COMMAND, '0, '0, 1'b0, CMD_CONTINUE);
      send_item(ACT_SAMPLE, 17'd99000, '0, 1'b0, '0);      // fine path
      send_item(ACT_COMMAND, '0, '0, 1'b0, CMD_PAUSE);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == PHASES - 1) idle_on = 1'b0;
         case (phase)
            0: configure(2, 4, 2000, 200, 1000, 2400, 6, 10);
            1: configure(1, 0, 0, 0, 0, 0, 0, 0);
            2: configure(65535, 65535, SP_MAX, 1023, 65535, 65535, 65535, 1023);
            3: configure(3, 6, $urandom_range(0, 20000), $urandom_range(0, 1023),
                         $urandom_range(0, 65535), 100, 5000, $urandom_range(0, 30));
            // zero threshold with large gain drives the coarse path into saturation
            4: configure(1, 2, 0, 1023, $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 100), 0);
            default: configure($urandom_range(1, 4), $urandom_range(0, 12),
                               $urandom_range(0, 1) ? $urandom_range(0, 5000)
                                                    : $urandom_range(0, SP_MAX),
                               $urandom_range(0, 1023), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 3000),
                               $urandom_range(0, 1) ? $urandom_range(0, 30)
                                                    : $urandom_range(0, 1023));
         endcase
         if (phase == 2) hold_requested = 1'b1;
         if (phase == 1) begin
            // fill the table, then offer two loads that must be dropped
            send_item(ACT_LOAD, SP_W'($urandom()), SP_W'($urandom_range(0, SP_MAX)),
                      1'b1, 3'($urandom()));
            repeat (TABLE_DEPTH + 1)
               send_item(ACT_LOAD, SP_W'($urandom()), SP_W'($urandom_range(0, SP_MAX)),
                         1'b0, 3'($urandom()));
            send_item(ACT_COMMAND, SP_W'($urandom()), SP_W'($urandom()), 1'($urandom()),
                      CMD_START);
            repeat (60)
               send_item($urandom_range(0, 3) == 0 ? ACT_SAMPLE : ACT_TICK,
                         SP_W'($urandom()), SP_W'($urandom()), 1'($urandom()),
                         3'($urandom()));
         end
         stop_at = items_sent + PHASE_ITEMS;
         while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 6))
                  send_item(action_type'($urandom_range(0, 3)), SP_W'($urandom()),
                            SP_W'($urandom()), 1'($urandom()), 3'($urandom()));
            end else begin
               // load a short list, start it, then run ticks, samples, commands and loads around it
               n_loaded = $urandom_range(1, 8);
               for (int i = 0; i < n_loaded; i++) begin
                  loaded[i] = ($urandom_range(0, 3) == 0)
                              ? SP_W'($urandom_range(0, SP_MAX))
                              : SP_W'($urandom_range(0, SETPOINT_CAP));
                  send_item(ACT_LOAD, SP_W'($urandom()), loaded[i],
                            (i == 0) ? ($urandom_range(0, 5) != 0) : 1'b0,
                            3'($urandom()));
               end
               send_item(ACT_COMMAND, SP_W'($urandom()), SP_W'($urandom()), 1'($urandom()),
                         CMD_START);
               repeat ($urandom_range(5, 40)) begin
                  roll = $urandom_range(0, 99);
                  if (roll < 55) begin
                     send_item(ACT_TICK, SP_W'($urandom()), SP_W'($urandom()),
                               1'($urandom()), 3'($urandom()));
                  end else if (roll < 88) begin
                     base = loaded[$urandom_range(0, n_loaded - 1)];
                     if (base > SETPOINT_CAP) base = SETPOINT_CAP;
                     pick = $urandom_range(0, 3);
                     if (pick == 0) begin
                        pres_i = $urandom_range(0, SP_MAX);
                     end else begin
                        delta = $urandom_range(0, pick == 1 ? 15 : pick == 2 ? 3000 : 40000);
                        pres_i = $urandom_range(0, 1) ? int'(base) + delta
                                                      : int'(base) - delta;
                        if (pres_i < 0) pres_i = 0;
                        if (pres_i > SP_MAX) pres_i = SP_MAX;
                     end
                     send_item(ACT_SAMPLE, SP_W'(pres_i), SP_W'($urandom()),
                               1'($urandom()), 3'($urandom()));
                  end else if (roll < 96) begin
                     send_item(ACT_COMMAND, SP_W'($urandom()), SP_W'($urandom()),
                               1'($urandom()), 3'($urandom_range(0, 7)));
                  end else begin
                     send_item(ACT_LOAD, SP_W'($urandom()), SP_W'($urandom_range(0, SP_MAX)),
                               $urandom_range(0, 3) == 0, 3'($urandom()));
                  end
               end
            end
         end
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
